[design/cll_pkg.sv]
// Shared command and status codes for the circular list block.
`default_nettype none
package cll_pkg;
	localparam int CMD_W = 3;
	localparam int STAT_W = 2;
	localparam int VAL_W = 32;

	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SHOW   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ADV    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEL    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_HEAD   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_TAIL   = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	typedef logic [VAL_W-1:0] word_t;
endpackage
`default_nettype wire

[design/cll_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
`default_nettype none
module cll_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

[design/circular_list_with_cursor_top.sv]
// Circular singly linked list with head, tail and cursor, held in a node pool.
//
// Input channel (in_valid/in_ready): one word per command, cmd plus item_value.
// Output channel (out_valid/out_ready): result words of out_value, status, last.
// Every command gives at least one word; last marks its final word.
// The node values and next links sit in two synchronous RAMs; a small sequencer
// reads, modifies and writes them back.
// States from accept to result: S_FIN for go head, go tail, status-only results
// and insert into an empty list; S_INS, S_INS2, S_FIN for other inserts; S_ADV,
// S_VAL for advance; S_DEL, S_DEL2 (not if tail/only node), S_VAL for delete;
// S_SHOW for show: one word per cycle while the output register is free.
// The next command is taken the cycle after the last word of the current one
// has been loaded into the output register, so the block takes a new word
// while that result still waits for the receiver.
// When the receiver stalls, the sequencer holds its position and RAM read data
// until the output register frees up; nothing is dropped.
// Reset empties the list (pointers and count to zero, all slots free); the
// RAM contents are not cleared since a free slot is never read.
`default_nettype none
module circular_list_with_cursor_top #(
	parameter int CAPACITY = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [cll_pkg::CMD_W-1:0] cmd,
	input  wire logic signed [31:0]       item_value,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [31:0]            out_value,
	output logic [cll_pkg::STAT_W-1:0]    status,
	output logic                          last
);
	import cll_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SHOW = 4'd1;
	localparam logic [3:0] S_ADV  = 4'd2;
	localparam logic [3:0] S_DEL  = 4'd3;
	localparam logic [3:0] S_DEL2 = 4'd4;
	localparam logic [3:0] S_INS  = 4'd5;
	localparam logic [3:0] S_INS2 = 4'd6;
	localparam logic [3:0] S_VAL  = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;

	logic [3:0]          state_q, state_d;
	logic [IW-1:0]       head_q, head_d, tail_q, tail_d, cursor_q, cursor_d;
	logic [CW-1:0]       cnt_q, cnt_d, show_q, show_d;
	logic [CAPACITY-1:0] used_q, used_d;
	logic [IW-1:0]       victim_q, victim_d, slot_q, slot_d;
	logic [STAT_W-1:0]   res_q, res_d;

	logic [IW-1:0] free_idx;
	logic          list_empty, list_full, can_emit;

	// RAM ports
	logic          link_we, link_re, val_we, val_re;
	logic [IW-1:0] link_waddr, link_wdata, link_raddr, link_rdata;
	logic [IW-1:0] val_waddr, val_raddr;
	word_t         val_wdata, val_rdata;

	// result going into the output register
	logic              emit, emit_last;
	word_t             emit_value;
	logic [STAT_W-1:0] emit_status;

	logic              out_valid_q, last_q;
	word_t             out_value_q;
	logic [STAT_W-1:0] status_q;

	cll_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_link (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	cll_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_wdata),
		.re    (val_re),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	// lowest free pool slot
	always_comb begin
		free_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = IW'(i);
			end
		end
	end

	assign list_empty = (cnt_q == '0);
	assign list_full  = (cnt_q == CW'(CAPACITY));
	assign can_emit   = !out_valid_q || out_ready;
	assign in_ready   = (state_q == S_IDLE);

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		cursor_d    = cursor_q;
		cnt_d       = cnt_q;
		show_d      = show_q;
		used_d      = used_q;
		victim_d    = victim_q;
		slot_d      = slot_q;
		res_d       = res_q;
		link_we     = 1'b0;
		link_waddr  = cursor_q;
		link_wdata  = link_rdata;
		link_re     = 1'b0;
		link_raddr  = cursor_q;
		val_we      = 1'b0;
		val_waddr   = free_idx;
		val_wdata   = word_t'(item_value);
		val_re      = 1'b0;
		val_raddr   = link_rdata;
		emit        = 1'b0;
		emit_value  = '0;
		emit_status = STAT_OK;
		emit_last   = 1'b1;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (cmd)
						CMD_INSERT: begin
							if (list_full) begin
								res_d   = STAT_FULL;
								state_d = S_FIN;
							end else if (list_empty) begin
								// new node links to itself
								link_we            = 1'b1;
								link_waddr         = free_idx;
								link_wdata         = free_idx;
								val_we             = 1'b1;
								head_d             = free_idx;
								tail_d             = free_idx;
								cursor_d           = free_idx;
								cnt_d              = cnt_q + CW'(1);
								used_d[free_idx]   = 1'b1;
								res_d              = STAT_OK;
								state_d            = S_FIN;
							end else begin
								val_we     = 1'b1;
								link_re    = 1'b1;
								link_raddr = cursor_q;
								slot_d     = free_idx;
								state_d    = S_INS;
							end
						end
						CMD_SHOW, CMD_ADV, CMD_DEL, CMD_HEAD, CMD_TAIL: begin
							if (list_empty) begin
								res_d   = STAT_EMPTY;
								state_d = S_FIN;
							end else begin
								case (cmd)
									CMD_SHOW: begin
										link_re    = 1'b1;
										link_raddr = head_q;
										val_re     = 1'b1;
										val_raddr  = head_q;
										show_d     = cnt_q;
										cursor_d   = head_q;
										state_d    = S_SHOW;
									end
									CMD_ADV: begin
										link_re = 1'b1;
										state_d = S_ADV;
									end
									CMD_DEL: begin
										link_re = 1'b1;
										state_d = S_DEL;
									end
									CMD_HEAD: begin
										cursor_d = head_q;
										res_d    = STAT_OK;
										state_d  = S_FIN;
									end
									default: begin
										cursor_d = tail_q;
										res_d    = STAT_OK;
										state_d  = S_FIN;
									end
								endcase
							end
						end
						default: begin
							res_d   = STAT_OK;
							state_d = S_FIN;
						end
					endcase
				end
			end
			S_SHOW: begin
				if (can_emit) begin
					emit       = 1'b1;
					emit_value = val_rdata;
					emit_last  = (show_q == CW'(1));
					show_d     = show_q - CW'(1);
					if (show_q == CW'(1)) begin
						state_d = S_IDLE;
					end else begin
						link_re    = 1'b1;
						link_raddr = link_rdata;
						val_re     = 1'b1;
						val_raddr  = link_rdata;
					end
				end
			end
			S_ADV: begin
				cursor_d  = link_rdata;
				val_re    = 1'b1;
				val_raddr = link_rdata;
				state_d   = S_VAL;
			end
			S_DEL: begin
				// link_rdata is the node after the cursor
				victim_d           = link_rdata;
				val_re             = 1'b1;
				val_raddr          = link_rdata;
				link_re            = 1'b1;
				link_raddr         = link_rdata;
				used_d[link_rdata] = 1'b0;
				cnt_d              = cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					head_d   = '0;
					tail_d   = '0;
					cursor_d = '0;
					state_d  = S_VAL;
				end else if (link_rdata == head_q) begin
					state_d = S_DEL2;
				end else if (link_rdata == tail_q) begin
					tail_d     = cursor_q;
					link_we    = 1'b1;
					link_waddr = cursor_q;
					link_wdata = head_q;
					state_d    = S_VAL;
				end else begin
					state_d = S_DEL2;
				end
			end
			S_DEL2: begin
				// link_rdata is the node after the deleted one
				link_we = 1'b1;
				if (victim_q == head_q) begin
					head_d     = link_rdata;
					link_waddr = tail_q;
				end else begin
					link_waddr = cursor_q;
				end
				link_wdata = link_rdata;
				state_d    = S_VAL;
			end
			S_INS: begin
				link_we    = 1'b1;
				link_waddr = slot_q;
				link_wdata = link_rdata;
				state_d    = S_INS2;
			end
			S_INS2: begin
				link_we    = 1'b1;
				link_waddr = cursor_q;
				link_wdata = slot_q;
				if (cursor_q == tail_q) begin
					tail_d = slot_q;
				end
				cursor_d       = slot_q;
				cnt_d          = cnt_q + CW'(1);
				used_d[slot_q] = 1'b1;
				res_d          = STAT_OK;
				state_d        = S_FIN;
			end
			S_VAL: begin
				if (can_emit) begin
					emit       = 1'b1;
					emit_value = val_rdata;
					state_d    = S_IDLE;
				end
			end
			S_FIN: begin
				if (can_emit) begin
					emit        = 1'b1;
					emit_status = res_q;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			cursor_q    <= '0;
			cnt_q       <= '0;
			show_q      <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			cursor_q <= cursor_d;
			cnt_q    <= cnt_d;
			show_q   <= show_d;
			used_q   <= used_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		victim_q <= victim_d;
		slot_q   <= slot_d;
		res_q    <= res_d;
		if (emit) begin
			out_value_q <= emit_value;
			status_q    <= emit_status;
			last_q      <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = signed'(out_value_q);
	assign status    = status_q;
	assign last      = last_q;
endmodule
`default_nettype wire

[design/cll_checker.sv]
// Port-level checker for the circular list block, bound to the top level.
`default_nettype none
module cll_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_ready,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic signed [31:0]        out_value,
	input wire logic [cll_pkg::STAT_W-1:0] status,
	input wire logic                      last
);
	import cll_pkg::*;

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value)
			&& $stable(status) && $stable(last))
		else $error("result word changed while stalled");

	// one command at a time: never two accepts in a row
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command taken while previous one in flight");

	// empty or full reports are single status-only words
	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> last && out_value == 32'sd0)
		else $error("empty/full report carries value or is not last");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == STAT_OK || status == STAT_EMPTY || status == STAT_FULL)
		else $error("undefined status code");
endmodule

bind circular_list_with_cursor_top cll_checker u_cll_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_value (out_value),
	.status    (status),
	.last      (last)
);
`default_nettype wire
